// ----- src/qdi_pkg.sv -----
package qdi_pkg;

	// pulse counter width
	localparam int COUNT_WIDTH = 32;
	// width of the counter and revolution ports
	localparam int PORT_W      = 32;
	localparam int INTERVAL_W  = 31;
	localparam int PPR_W       = 16;
	// bits of the divider iteration counter
	localparam int CNT_W       = $clog2(COUNT_WIDTH);

	localparam logic [INTERVAL_W-1:0] INTERVAL_SAT = {INTERVAL_W{1'b1}};

	// configuration register indexes
	localparam logic REG_ENCODING_MODE  = 1'b0;
	localparam logic REG_PULSES_PER_REV = 1'b1;

	// encoding modes
	localparam logic MODE_X2 = 1'b0;
	localparam logic MODE_X4 = 1'b1;

	// input actions
	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	// channel level pairs, a in bit 1, b in bit 0
	localparam logic [1:0] LVL_BOTH_LOW  = 2'b00;
	localparam logic [1:0] LVL_BOTH_HIGH = 2'b11;
	localparam logic [1:0] LVL_DIFF_B    = 2'b01;
	localparam logic [1:0] LVL_DIFF_A    = 2'b10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_HOLD
	} qdi_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ----- src/quadrature_decoder_with_interval.sv -----
// quadrature decoder with edge interval measurement
//
// input channel: in_valid/in_ready, one transaction per microsecond tick
// (action = tick) with the sampled levels channel_a/channel_b, or a clear
// command (action = clear) that zeroes the pulse count and the interval
// output channel: out_valid/out_ready, one transaction per input transaction
// carrying pulse_count, revolutions, edge_interval_us and edge_seen
// config: cfg_write/cfg_index/cfg_data, index 0 encoding_mode (0 x2, 1 x4),
// index 1 pulses_per_rev (0 acts as 1); write only while idle
//
// the decode step and the counter update happen in the accepting cycle;
// revolutions come from a restoring divider that resolves one quotient bit
// per cycle, and in_ready is low until the division has finished, so no new
// input is taken while one is still in the divider
// a finished result sits in the output register, so the next input is taken
// while it waits; if the receiver stalls past the next division the
// quotient is held in the divider and in_ready stays low until the output
// register frees up
// reset: encoding_mode x4, pulses_per_rev 1, counter 0, interval saturated,
// decoder unprimed (the first tick only captures the levels)
module quadrature_decoder_with_interval (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic                                  cfg_index,
	input  logic [qdi_pkg::PPR_W-1:0]             cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  action,
	input  logic                                  channel_a,
	input  logic                                  channel_b,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [qdi_pkg::PORT_W-1:0]     pulse_count,
	output logic signed [qdi_pkg::PORT_W-1:0]     revolutions,
	output logic [qdi_pkg::INTERVAL_W-1:0]        edge_interval_us,
	output logic                                  edge_seen
);
	import qdi_pkg::*;

	// configuration
	logic             mode_q;
	logic [PPR_W-1:0] ppr_q;

	// decoder state
	logic                   primed_q;
	logic [1:0]             last_q;
	logic [1:0]             prev_q;
	logic [COUNT_WIDTH-1:0] pulses_q;
	logic [INTERVAL_W-1:0]  elapsed_q;
	logic [INTERVAL_W-1:0]  interval_q;

	// staged result fields waiting for the quotient
	logic [COUNT_WIDTH-1:0] stg_pulses_q;
	logic                   stg_seen_q;

	// output register
	logic                   out_valid_q;
	logic [PORT_W-1:0]      pulse_count_q;
	logic [PORT_W-1:0]      revolutions_q;
	logic [INTERVAL_W-1:0]  interval_out_q;
	logic                   seen_out_q;

	qdi_state_t state_q;
	qdi_state_t state_nxt;

	logic in_take;
	logic div_start;
	logic load_out;
	logic out_free;

	// next-state decode
	logic [1:0]             cur;
	logic [1:0]             changed;
	logic                   edge_hit;
	logic [INTERVAL_W-1:0]  elapsed_inc;
	logic                   step_up;
	logic                   step_down;
	logic                   primed_nxt;
	logic [1:0]             last_nxt;
	logic [1:0]             prev_nxt;
	logic [COUNT_WIDTH-1:0] pulses_nxt;
	logic [INTERVAL_W-1:0]  elapsed_nxt;
	logic [INTERVAL_W-1:0]  interval_nxt;
	logic                   seen_nxt;

	logic [COUNT_WIDTH-1:0]        div_dividend;
	logic                          div_neg;
	logic [PPR_W-1:0]              div_divisor;
	div_status_t                   div_stat;
	logic signed [COUNT_WIDTH-1:0] div_quotient;

	assign cur         = {channel_a, channel_b};
	assign changed     = last_q ^ cur;
	assign edge_hit    = (mode_q == MODE_X2) ? changed[1] : (changed != LVL_BOTH_LOW);
	assign elapsed_inc = (elapsed_q == INTERVAL_SAT) ? elapsed_q : elapsed_q + 1'b1;

	// direction of one decode step
	always_comb begin
		step_up   = 1'b0;
		step_down = 1'b0;
		if (mode_q == MODE_X2) begin
			if ((prev_q == LVL_BOTH_HIGH && cur == LVL_BOTH_LOW) ||
			    (prev_q == LVL_BOTH_LOW && cur == LVL_BOTH_HIGH)) begin
				step_up = 1'b1;
			end else begin
				step_down = 1'b1;
			end
		end else begin
			// x4: only a single-bit change counts, both-bit change is ignored
			if ((prev_q ^ cur) == LVL_DIFF_B || (prev_q ^ cur) == LVL_DIFF_A) begin
				if (prev_q[0] == cur[1]) begin
					step_up = 1'b1;
				end else begin
					step_down = 1'b1;
				end
			end
		end
	end

	always_comb begin
		primed_nxt   = primed_q;
		last_nxt     = last_q;
		prev_nxt     = prev_q;
		pulses_nxt   = pulses_q;
		elapsed_nxt  = elapsed_q;
		interval_nxt = interval_q;
		seen_nxt     = 1'b0;
		priority if (action == ACT_CLEAR) begin
			// clear is not a tick: elapsed time, levels and priming stay
			pulses_nxt   = '0;
			interval_nxt = '0;
		end else if (!primed_q) begin
			primed_nxt  = 1'b1;
			last_nxt    = cur;
			prev_nxt    = cur;
			elapsed_nxt = '0;
		end else begin
			last_nxt    = cur;
			elapsed_nxt = elapsed_inc;
			if (edge_hit) begin
				prev_nxt     = cur;
				interval_nxt = elapsed_inc;
				elapsed_nxt  = '0;
				seen_nxt     = 1'b1;
				if (step_up) begin
					pulses_nxt = pulses_q + 1'b1;
				end else if (step_down) begin
					pulses_nxt = pulses_q - 1'b1;
				end
			end
		end
	end

	// divider gets the magnitude, sign applied on the way out
	assign div_neg      = pulses_nxt[COUNT_WIDTH-1];
	assign div_dividend = div_neg ? (~pulses_nxt + 1'b1) : pulses_nxt;
	assign div_divisor  = (ppr_q == '0) ? PPR_W'(1) : ppr_q;

	qdi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.neg      (div_neg),
		.divisor  (div_divisor),
		.status   (div_stat),
		.quotient (div_quotient)
	);

	assign out_free = ~out_valid_q | out_ready;
	assign in_take  = in_valid & in_ready;

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_stat.done) begin
					state_nxt = out_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				div_start = in_valid;
			end
			ST_DIVIDE: begin
				load_out = div_stat.done & out_free;
			end
			ST_HOLD: begin
				load_out = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_X4;
			ppr_q       <= PPR_W'(1);
			primed_q    <= 1'b0;
			last_q      <= LVL_BOTH_LOW;
			prev_q      <= LVL_BOTH_LOW;
			pulses_q    <= '0;
			elapsed_q   <= '0;
			interval_q  <= INTERVAL_SAT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_write) begin
				unique case (cfg_index)
					REG_ENCODING_MODE:  mode_q <= cfg_data[0];
					REG_PULSES_PER_REV: ppr_q  <= cfg_data;
					default:            mode_q <= mode_q;
				endcase
			end
			if (in_take) begin
				primed_q   <= primed_nxt;
				last_q     <= last_nxt;
				prev_q     <= prev_nxt;
				pulses_q   <= pulses_nxt;
				elapsed_q  <= elapsed_nxt;
				interval_q <= interval_nxt;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_take) begin
			stg_pulses_q <= pulses_nxt;
			stg_seen_q   <= seen_nxt;
		end
		if (load_out) begin
			pulse_count_q  <= PORT_W'(stg_pulses_q);
			revolutions_q  <= PORT_W'(div_quotient);
			interval_out_q <= interval_q;
			seen_out_q     <= stg_seen_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign pulse_count      = $signed(pulse_count_q);
	assign revolutions      = $signed(revolutions_q);
	assign edge_interval_us = interval_out_q;
	assign edge_seen        = seen_out_q;

	// a transaction always launches a division
	a_take_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> div_stat.busy)
		else $error("division not started after input transaction");

	// no new input while the divider runs
	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && div_stat.busy))
		else $error("input ready while divider busy");

	// divider completion only seen while the sequencer waits for it
	a_done_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIVIDE)
		else $error("divider finished outside divide state");

	// an edge can only be reported once the decoder is primed
	a_seen_needs_primed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && seen_out_q) |-> primed_q)
		else $error("edge reported before priming");

endmodule

// ----- src/qdi_div.sv -----
module qdi_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [qdi_pkg::COUNT_WIDTH-1:0]        dividend,
	input  logic                                   neg,
	input  logic [qdi_pkg::PPR_W-1:0]              divisor,
	output qdi_pkg::div_status_t                   status,
	output logic signed [qdi_pkg::COUNT_WIDTH-1:0] quotient
);
	import qdi_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [PPR_W-1:0]       rem_q;
	logic [PPR_W-1:0]       dvs_q;
	logic [COUNT_WIDTH-1:0] quo_q;
	logic                   neg_q;

	logic [PPR_W:0] shifted;
	logic [PPR_W:0] trial;
	logic           trial_ok;

	// one restoring step per cycle
	assign shifted  = {rem_q, quo_q[COUNT_WIDTH-1]};
	assign trial    = shifted - {1'b0, dvs_q};
	assign trial_ok = ~trial[PPR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(COUNT_WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= trial_ok ? trial[PPR_W-1:0] : shifted[PPR_W-1:0];
			quo_q <= {quo_q[COUNT_WIDTH-2:0], trial_ok};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule
